/* design/mab_pkg.sv */
// Package for the multi-arena bump allocator: action codes, configuration
// register indexes and stream payload widths.
// No dependencies; imported by multi_arena_bump_allocator_core.
package mab_pkg;

  // Request kinds carried in s_tuser.
  typedef enum logic [1:0] {
    ACT_ALLOC         = 2'd0,
    ACT_ALLOC_ALIGNED = 2'd1,
    ACT_REWIND        = 2'd2,
    ACT_QUERY         = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ARENA_COUNT = 3'd0;
  localparam logic [2:0] REG_ENABLE_MASK = 3'd1;
  localparam logic [2:0] REG_ARENA0_BASE = 3'd2;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 32;

  // Alignment span is 32 bytes, so the pad is 5 bits wide.
  localparam int AlignBits = 5;

  // Field widths.
  localparam int ActionBits = 2;
  localparam int IndexBits  = 3;
  localparam int SizeBits   = 32;
  localparam int OffsetBits = 32;
  localparam int AddrOutBits = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int InDataBits  = 72;
  localparam int OutDataBits = 40;

endpackage

/* design/multi_arena_bump_allocator_core.sv */
// Multi-arena bump allocator core: request stream in, one result per request out.
// Depends on mab_pkg (action codes, register indexes, payload widths).
//
// Usage notes
// - Requests arrive on the s_* stream: s_tuser carries the action, s_tdata the
//   arena index, request size and alignment offset. A transaction completes when
//   s_tvalid and s_tready are both high at a rising clock edge.
// - Each request produces exactly one result on the m_* stream: granted flag,
//   granted address and query answer.
// - m_tvalid rises after the input transaction: the request register loads at the
//   accepting edge, the allocation decision and arena update load the result
//   register when free or draining. One request per cycle is sustained while
//   m_tready is high; the used-byte counters update in the same edge that loads
//   the result, so back-to-back requests to one arena see each other's updates.
// - When the receiver stalls, the result register holds and the request register
//   can still fill once; after that s_tready drops until m_tready returns.
// - The configuration channel (cfg_*) is always ready and should be written only
//   while no request is in flight.
// - Synchronous reset clears the configuration registers, all used-byte counters
//   and empties both pipeline registers; requests are taken once rst is low.
module multi_arena_bump_allocator_core #(
  parameter int ARENAS    = 3,
  parameter int ADDR_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: arena_index[2:0], request_size[34:3], align_offset[66:35], zero fill
  input  logic [mab_pkg::InDataBits-1:0]    s_tdata,
  // s_tuser: action[1:0]
  input  logic [mab_pkg::ActionBits-1:0]    s_tuser,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: granted[0], grant_address[32:1], arena_enabled[33], zero fill
  output logic [mab_pkg::OutDataBits-1:0]   m_tdata,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mab_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [mab_pkg::CfgDataBits-1:0]   cfg_data
);
  import mab_pkg::*;

  localparam int EndBits = 34;
  localparam logic [2:0] ArenasVal = 3'(ARENAS);

  // Configuration registers
  logic [1:0]  arena_count;
  logic [2:0]  arena_enable_mask;
  logic [31:0] arena_base  [ARENAS];
  logic [31:0] arena_limit [ARENAS];

  // Arena state
  logic [31:0] used [ARENAS];

  // Request register
  logic                  in_valid;
  action_t               in_action;
  logic [IndexBits-1:0]  in_index;
  logic [SizeBits-1:0]   in_size;
  logic [AlignBits-1:0]  in_align;

  // Result register
  logic                   out_valid;
  logic                   out_granted;
  logic [AddrOutBits-1:0] out_address;
  logic                   out_enabled;

  // Decision logic
  logic                 adv;
  logic                 idx_ok;
  logic                 sel_en;
  logic [31:0]          sel_base;
  logic [31:0]          sel_limit;
  logic [31:0]          sel_used;
  logic [ADDR_BITS-1:0] cur;
  logic [AlignBits-1:0] pad;
  logic [ADDR_BITS:0]   start;
  logic [EndBits-1:0]   end_ptr;
  logic                 fits;
  logic                 is_alloc;
  logic                 do_alloc;
  logic [31:0]          used_next;
  logic                 granted_next;
  logic [AddrOutBits-1:0] address_next;
  logic                 enabled_next;

  assign cfg_ready = 1'b1;

  // The request register advances when the result register is free or draining.
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_count       <= '0;
      arena_enable_mask <= '0;
      for (int i = 0; i < ARENAS; i++) begin
        arena_base[i]  <= '0;
        arena_limit[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ARENA_COUNT) begin
        arena_count <= cfg_data[1:0];
      end
      if (cfg_index == REG_ENABLE_MASK) begin
        arena_enable_mask <= cfg_data[2:0];
      end
      for (int i = 0; i < ARENAS; i++) begin
        if (cfg_index == REG_ARENA0_BASE + 3'(2 * i)) begin
          arena_base[i] <= cfg_data;
        end
        if (cfg_index == REG_ARENA0_BASE + 3'(2 * i + 1)) begin
          arena_limit[i] <= cfg_data;
        end
      end
    end
  end

  // Request register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= action_t'(s_tuser);
      in_index  <= s_tdata[2:0];
      in_size   <= s_tdata[34:3];
      in_align  <= s_tdata[35 +: AlignBits];
    end
  end

  // Arena selection: the index must be non-negative, counted and implemented.
  always_comb begin
    idx_ok    = !in_index[2] && (in_index[1:0] < arena_count)
                && ({1'b0, in_index[1:0]} < ArenasVal);
    sel_en    = 1'b0;
    sel_base  = '0;
    sel_limit = '0;
    sel_used  = '0;
    for (int i = 0; i < ARENAS; i++) begin
      if (2'(i) == in_index[1:0]) begin
        sel_en    = arena_enable_mask[i];
        sel_base  = arena_base[i];
        sel_limit = arena_limit[i];
        sel_used  = used[i];
      end
    end
  end

  // Pointer arithmetic. The end pointer is kept wide enough that any carry out
  // of the address space shows up as exceeding the limit.
  always_comb begin
    is_alloc = (in_action == ACT_ALLOC) || (in_action == ACT_ALLOC_ALIGNED);
    do_alloc = is_alloc && idx_ok && sel_en;
    cur      = sel_base[ADDR_BITS-1:0] + sel_used[ADDR_BITS-1:0];
    if (in_action == ACT_ALLOC_ALIGNED) begin
      pad = in_align - cur[AlignBits-1:0];
    end else begin
      pad = '0;
    end
    start   = {1'b0, cur} + (ADDR_BITS + 1)'(pad);
    end_ptr = EndBits'(start) + EndBits'(in_size);
    fits    = end_ptr <= EndBits'(sel_limit[ADDR_BITS-1:0]);
    // On a failed aligned request the pad is still consumed.
    used_next = sel_used + 32'(pad) + (fits ? in_size : 32'd0);
  end

  // Result fields
  always_comb begin
    granted_next = 1'b0;
    address_next = '0;
    enabled_next = 1'b0;
    unique case (in_action)
      ACT_ALLOC, ACT_ALLOC_ALIGNED: begin
        if (do_alloc && fits) begin
          granted_next = 1'b1;
          address_next = AddrOutBits'(start[ADDR_BITS-1:0]);
        end
      end
      ACT_REWIND: begin
        granted_next = 1'b1;
      end
      ACT_QUERY: begin
        enabled_next = idx_ok && sel_en;
      end
      default: begin
        granted_next = 1'b0;
      end
    endcase
  end

  // Arena counter update, in the same edge that loads the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ARENAS; i++) begin
        used[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < ARENAS; i++) begin
        if (in_action == ACT_REWIND && 2'(i) < arena_count) begin
          used[i] <= '0;
        end else if (do_alloc && 2'(i) == in_index[1:0]) begin
          used[i] <= used_next;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_granted <= granted_next;
      out_address <= address_next;
      out_enabled <= enabled_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_enabled, out_address, out_granted};

  // An allocation with an out-of-range arena index leaves arena zero's counter untouched.
  a_reject_keeps_used: assert property (@(posedge clk) disable iff (rst)
    adv && is_alloc && !idx_ok |=> $stable(used[0]))
    else $error("rejected allocation changed arena state");

  // A rewind with at least one counted arena empties arena zero.
  a_rewind_clears: assert property (@(posedge clk) disable iff (rst)
    adv && in_action == ACT_REWIND && arena_count != 2'd0 |=> used[0] == 32'd0)
    else $error("rewind did not clear arena zero");

  // A refused request never reports an address.
  a_no_address_on_refusal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_granted |-> out_address == '0)
    else $error("address reported without a grant");

endmodule
